// File: sv/gp_timer_with_reload_and_compare_defines.svh
// Assertion macros for the general purpose timer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef GP_TIMER_WITH_RELOAD_AND_COMPARE_DEFINES_SVH
`define GP_TIMER_WITH_RELOAD_AND_COMPARE_DEFINES_SVH

// Checked only while the block is out of reset.
`define GPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define GPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/gpt_pkg.sv
// Types and constants shared by the general purpose timer modules.
// No dependencies.
package gpt_pkg;

  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    ReqTick  = 2'd0,
    ReqRead  = 2'd1,
    ReqWrite = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    RegCtrl      = 3'd0,
    RegCounter   = 3'd1,
    RegLoad      = 3'd2,
    RegMatch     = 3'd3,
    RegStatus    = 3'd4,
    RegIrqEnable = 3'd5,
    RegSoftReset = 3'd6,
    RegResetDone = 3'd7
  } reg_sel_e;

  // Control bit positions.
  localparam int unsigned CtlStart   = 0;
  localparam int unsigned CtlReload  = 1;
  localparam int unsigned CtlCompare = 2;

  // Status and interrupt enable bit positions.
  localparam int unsigned FlgMatch   = 0;
  localparam int unsigned FlgOver    = 1;
  localparam int unsigned FlgCapture = 2;

  localparam int unsigned SoftResetBit = 1;
  localparam logic [DataWidth-1:0] ResetDoneValue = 32'd1;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [2:0]           reg_sel;
    logic [DataWidth-1:0] write_value;
  } gpt_req_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_value;
    logic                 irq_line;
  } gpt_rsp_t;

endpackage

// File: sv/gpt_req_if.sv
// Request channel of the general purpose timer: valid, ready and payload.
// Depends on gpt_pkg for the data width.
interface gpt_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic [2:0]                     reg_sel;
  logic [gpt_pkg::DataWidth-1:0]  write_value;

  modport source (output valid, output req_type, output reg_sel, output write_value,
                  input ready);
  modport sink (input valid, input req_type, input reg_sel, input write_value,
                output ready);
endinterface

// File: sv/gpt_rsp_if.sv
// Result channel of the general purpose timer: valid, ready and payload.
// Depends on gpt_pkg for the data width.
interface gpt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [gpt_pkg::DataWidth-1:0]  read_value;
  logic                           irq_line;

  modport source (output valid, output read_value, output irq_line, input ready);
  modport sink (input valid, input read_value, input irq_line, output ready);
endinterface

// File: sv/gpt_core.sv
// Timer state registers and the single-pass logic that executes one request.
// Depends on gpt_pkg.
module gpt_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  gpt_pkg::gpt_req_t req_i,
  output gpt_pkg::gpt_rsp_t rsp_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] reload_q, reload_d;
  logic [COUNT_WIDTH-1:0] match_q, match_d;
  logic [2:0]             ctrl_q, ctrl_d;
  logic [2:0]             flag_q, flag_d;
  logic [2:0]             enable_q, enable_d;
  logic [gpt_pkg::DataWidth-1:0] read_value;

  always_comb begin
    count_d    = count_q;
    reload_d   = reload_q;
    match_d    = match_q;
    ctrl_d     = ctrl_q;
    flag_d     = flag_q;
    enable_d   = enable_q;
    read_value = '0;
    unique case (gpt_pkg::req_type_e'(req_i.req_type))
      gpt_pkg::ReqTick: begin
        if (ctrl_q[gpt_pkg::CtlStart]) begin
          if (count_q == {COUNT_WIDTH{1'b1}}) begin
            flag_d[gpt_pkg::FlgOver] = 1'b1;
            if (ctrl_q[gpt_pkg::CtlReload]) begin
              count_d = reload_q;
            end else begin
              count_d = '0;
              ctrl_d[gpt_pkg::CtlStart] = 1'b0;
            end
          end else begin
            count_d = count_q + COUNT_WIDTH'(1);
          end
          if (ctrl_q[gpt_pkg::CtlCompare] && (count_d == match_q)) begin
            flag_d[gpt_pkg::FlgMatch] = 1'b1;
          end
        end
      end
      gpt_pkg::ReqRead: begin
        unique case (gpt_pkg::reg_sel_e'(req_i.reg_sel))
          gpt_pkg::RegCtrl:      read_value = gpt_pkg::DataWidth'(ctrl_q);
          gpt_pkg::RegCounter:   read_value = gpt_pkg::DataWidth'(count_q);
          gpt_pkg::RegLoad:      read_value = gpt_pkg::DataWidth'(reload_q);
          gpt_pkg::RegMatch:     read_value = gpt_pkg::DataWidth'(match_q);
          gpt_pkg::RegStatus:    read_value = gpt_pkg::DataWidth'(flag_q);
          gpt_pkg::RegIrqEnable: read_value = gpt_pkg::DataWidth'(enable_q);
          gpt_pkg::RegSoftReset: read_value = '0;
          gpt_pkg::RegResetDone: read_value = gpt_pkg::ResetDoneValue;
          default:               read_value = '0;
        endcase
      end
      gpt_pkg::ReqWrite: begin
        unique case (gpt_pkg::reg_sel_e'(req_i.reg_sel))
          gpt_pkg::RegCtrl:      ctrl_d   = req_i.write_value[2:0];
          gpt_pkg::RegCounter:   count_d  = COUNT_WIDTH'(req_i.write_value);
          gpt_pkg::RegLoad:      reload_d = COUNT_WIDTH'(req_i.write_value);
          gpt_pkg::RegMatch:     match_d  = COUNT_WIDTH'(req_i.write_value);
          gpt_pkg::RegStatus:    flag_d   = flag_q & ~req_i.write_value[2:0];
          gpt_pkg::RegIrqEnable: enable_d = req_i.write_value[2:0];
          gpt_pkg::RegSoftReset: begin
            if (req_i.write_value[gpt_pkg::SoftResetBit]) begin
              count_d  = '0;
              reload_d = '0;
              match_d  = '0;
              ctrl_d   = '0;
              flag_d   = '0;
              enable_d = '0;
            end
          end
          gpt_pkg::RegResetDone: ;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign rsp_o.read_value = read_value;
  assign rsp_o.irq_line   = |(flag_d & enable_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      reload_q <= '0;
      match_q  <= '0;
      ctrl_q   <= '0;
      flag_q   <= '0;
      enable_q <= '0;
    end else if (fire_i) begin
      count_q  <= count_d;
      reload_q <= reload_d;
      match_q  <= match_d;
      ctrl_q   <= ctrl_d;
      flag_q   <= flag_d;
      enable_q <= enable_d;
    end
  end

endmodule

// File: sv/gp_timer_with_reload_and_compare.sv
// General purpose timer with auto-reload and compare. Every request (a tick, a register
// read or a register write) is taken into an input register and executed against the timer
// state in one pass as it moves into the result register, so the block accepts one request
// per cycle while the result register is not stalled. The rate is set by the single
// state update per cycle in gpt_core; input ready follows result ready in the same
// cycle whenever both registers are full.
// Depends on gpt_pkg, gpt_req_if, gpt_rsp_if, gpt_core and the assertion macro header.
`include "gp_timer_with_reload_and_compare_defines.svh"

module gp_timer_with_reload_and_compare #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  gpt_req_if.sink   req_i,
  gpt_rsp_if.source rsp_o
);

  logic              s1_valid_q, s1_valid_d;
  gpt_pkg::gpt_req_t s1_q;
  logic              rsp_valid_q, rsp_valid_d;
  gpt_pkg::gpt_rsp_t rsp_q, core_rsp;
  logic              in_fire, s1_fire;

  assign s1_fire     = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_fire;
  assign in_fire     = req_i.valid && req_i.ready;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    rsp_valid_d = rsp_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    if (s1_fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.req_type    <= req_i.req_type;
      s1_q.reg_sel     <= req_i.reg_sel;
      s1_q.write_value <= req_i.write_value;
    end
    if (s1_fire) begin
      rsp_q <= core_rsp;
    end
  end

  gpt_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .req_i  (s1_q),
    .rsp_o  (core_rsp)
  );

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_value = rsp_q.read_value;
  assign rsp_o.irq_line   = rsp_q.irq_line;

  `GPT_ASSERT(a_stall_blocks_input, (s1_valid_q && rsp_valid_q && !rsp_o.ready) |-> !req_i.ready, "input accepted while both stages are stalled")
  `GPT_ASSERT(a_non_read_zero, (s1_fire && (s1_q.req_type != gpt_pkg::ReqRead)) |=> (rsp_o.read_value == '0), "tick or write returned nonzero data")
  `GPT_ASSERT(a_reset_done_one, (s1_fire && (s1_q.req_type == gpt_pkg::ReqRead) && (s1_q.reg_sel == gpt_pkg::RegResetDone)) |=> (rsp_o.read_value == gpt_pkg::ResetDoneValue), "reset done read did not return one")
  `GPT_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!s1_valid_q && !rsp_valid_q), "pipeline not empty during reset")

endmodule
